[hdl/ljc_pkg.sv]
// ----------------------------------------------------------------------------
// ljc_pkg: shared types and constants for the line junction classifier
// Junction codes, item function codes, register indexes and helper functions.
// ----------------------------------------------------------------------------
package ljc_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int CNT_W        = 8;
  localparam int POS_W        = 32;
  localparam int DIST_W       = 16;
  localparam int FUNC_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_DELAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_END       = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]  DEBOUNCE_LIMIT_RST = 8'd3;
  localparam logic [DIST_W-1:0] PASS_DELAY_RST     = 16'd30;
  localparam logic [DIST_W-1:0] DEAD_END_RST       = 16'd100;

  // Fixed report distances in mm
  localparam logic [POS_W-1:0] LOST_REPORT_MM = 32'd100;
  localparam logic [POS_W-1:0] F_REPORT_MM    = 32'd50;

  typedef enum logic [3:0] {
    J_NONE = 4'd0,
    J_G    = 4'd1,
    J_7    = 4'd2,
    J_T    = 4'd3,
    J_I    = 4'd4,
    J_X    = 4'd5,
    J_E    = 4'd6,
    J_3    = 4'd7,
    J_DEAD = 4'd8,
    J_F    = 4'd9
  } junction_t;

  typedef struct packed {
    logic [CNT_W-1:0]  debounce_limit;
    logic [DIST_W-1:0] pass_delay_mm;
    logic [DIST_W-1:0] dead_end_mm;
  } cfg_t;

  typedef struct packed {
    junction_t                current;
    logic [SENSOR_COUNT-1:0]  filtered;
    junction_t                passed;
    logic [POS_W-1:0]         passed_pos;
    logic                     flag;
  } result_t;

  // Decode a debounced pattern (0 = line seen, bit 0 leftmost)
  function automatic junction_t junction_of(input logic [SENSOR_COUNT-1:0] p);
    junction_t j;
    unique case (p)
      4'h1, 4'h3, 4'h5, 4'h7: j = J_G;
      4'h8, 4'hA, 4'hC, 4'hE: j = J_7;
      4'h0:                   j = J_T;
      4'h9, 4'hB, 4'hD:       j = J_I;
      default:                j = J_NONE;
    endcase
    return j;
  endfunction

  // Signed travel from one position to another reaches a limit
  function automatic logic reached(input logic [POS_W-1:0] from_pos,
                                   input logic [POS_W-1:0] to_pos,
                                   input logic [POS_W-1:0] limit);
    logic signed [POS_W-1:0] d;
    d = $signed(to_pos - from_pos);
    return d >= $signed(limit);
  endfunction

endpackage

[hdl/line_junction_classifier.sv]
// ----------------------------------------------------------------------------
// line_junction_classifier: line sensor debounce and junction classifier
// Debounces four line-sensor bits, decodes junctions and reports passed ones.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result item. An item is held in the
// input register while its whole update (debounce, decode, classification)
// runs combinationally into the result register, so a result reaches the
// outputs through the input register and then the result register; one item
// is taken per cycle when the output side keeps up.
// That rate is set by the classifier state update, made as the result is loaded.
// in_ready drops only while the input register is full and the result register
// is held by a stalled consumer. Sample items (func 0) debounce sensor_bits and
// track junctions at position_mm; clear items (func 1) reset detection at
// position_mm; read items (func 2) return the update flag and clear it. Every
// result shows the state after its item. Registers are written through the cfg
// port at any time, but take effect predictably only while no item is in
// flight; cfg_ready is always high and writes to index 3 are dropped.
module line_junction_classifier (
  input  logic                             clk,
  input  logic                             rst,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ljc_pkg::FUNC_W-1:0]       func,
  input  logic [ljc_pkg::SENSOR_COUNT-1:0] sensor_bits,
  input  logic signed [ljc_pkg::POS_W-1:0] position_mm,
  // result item channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       current_junction,
  output logic [ljc_pkg::SENSOR_COUNT-1:0] filtered_bits,
  output logic [3:0]                       passed_junction,
  output logic signed [ljc_pkg::POS_W-1:0] passed_position,
  output logic                             update_flag,
  // register write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ljc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ljc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ljc_pkg::*;

  // input register
  logic                    a_valid;
  logic [FUNC_W-1:0]       a_func;
  logic [SENSOR_COUNT-1:0] a_bits;
  logic [POS_W-1:0]        a_pos;

  // result register
  result_t                 res;
  result_t                 res_next;

  cfg_t                    cfg;
  logic                    advance;
  logic [SENSOR_COUNT-1:0] pattern_next;

  // Advance the held item when the result register is free or being emptied.
  assign advance  = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  // Payload holds no reset; load it on acceptance only.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_func <= func;
      a_bits <= sensor_bits;
      a_pos  <= position_mm;
    end
  end

  // Register writes; drop writes to unused indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg.pass_delay_mm  <= PASS_DELAY_RST;
      cfg.dead_end_mm    <= DEAD_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_LIMIT: cfg.debounce_limit <= cfg_data[CNT_W-1:0];
        CFG_PASS_DELAY:     cfg.pass_delay_mm  <= cfg_data[DIST_W-1:0];
        CFG_DEAD_END:       cfg.dead_end_mm    <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Debounce runs only on sample items.
  ljc_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .step         (advance && a_func == FUNC_SAMPLE),
    .raw          (a_bits),
    .limit        (cfg.debounce_limit),
    .pattern_next (pattern_next)
  );

  ljc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .func         (a_func),
    .pos          (a_pos),
    .pattern_next (pattern_next),
    .cfg          (cfg),
    .result       (res_next)
  );

  // Output register: hold the result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  assign current_junction = res.current;
  assign filtered_bits    = res.filtered;
  assign passed_junction  = res.passed;
  assign passed_position  = $signed(res.passed_pos);
  assign update_flag      = res.flag;

endmodule

[hdl/ljc_debounce.sv]
// ----------------------------------------------------------------------------
// ljc_debounce: sensor debounce
// One saturating up/down counter per sensor bit; sets or clears the bit.
// ----------------------------------------------------------------------------
module ljc_debounce (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [ljc_pkg::SENSOR_COUNT-1:0] raw,
  input  logic [ljc_pkg::CNT_W-1:0]        limit,
  output logic [ljc_pkg::SENSOR_COUNT-1:0] pattern_next
);
  import ljc_pkg::*;

  logic [CNT_W-1:0]        cnt      [SENSOR_COUNT];
  logic [CNT_W-1:0]        cnt_calc [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] pattern;
  logic [SENSOR_COUNT-1:0] pattern_calc;

  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      cnt_calc[i] = cnt[i];
      if (raw[i]) begin
        if (cnt[i] < limit) cnt_calc[i] = cnt[i] + 8'd1;
      end else if (cnt[i] != '0) begin
        cnt_calc[i] = cnt[i] - 8'd1;
      end
      pattern_calc[i] = pattern[i];
      if (cnt_calc[i] >= limit) begin
        pattern_calc[i] = 1'b1;
        cnt_calc[i]     = limit;
      end else if (cnt_calc[i] == '0) begin
        pattern_calc[i] = 1'b0;
      end
    end
  end

  assign pattern_next = step ? pattern_calc : pattern;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '1;
      for (int i = 0; i < SENSOR_COUNT; i++) cnt[i] <= '0;
    end else if (step) begin
      pattern <= pattern_calc;
      for (int i = 0; i < SENSOR_COUNT; i++) cnt[i] <= cnt_calc[i];
    end
  end

endmodule

[hdl/ljc_classify.sv]
// ----------------------------------------------------------------------------
// ljc_classify: junction tracking and classification
// Holds the junction history and positions; gives the state after each item.
// ----------------------------------------------------------------------------
module ljc_classify (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [ljc_pkg::FUNC_W-1:0]       func,
  input  logic [ljc_pkg::POS_W-1:0]        pos,
  input  logic [ljc_pkg::SENSOR_COUNT-1:0] pattern_next,
  input  ljc_pkg::cfg_t                    cfg,
  output ljc_pkg::result_t                 result
);
  import ljc_pkg::*;

  junction_t        now_junction, now_n;
  junction_t        held, held_n;
  junction_t        last_passed, last_n;
  logic             passed_flag, pflag_n;
  logic             handled, handled_n;
  logic [POS_W-1:0] lost_pos, lost_n;
  logic [POS_W-1:0] tee_pos, tee_n;
  logic [POS_W-1:0] nontriv_pos, nontriv_n;
  logic [POS_W-1:0] passed_pos, ppos_n;
  logic             flag_out;

  always_comb begin
    junction_t cur;
    junction_t prev;
    now_n     = now_junction;
    held_n    = held;
    last_n    = last_passed;
    pflag_n   = passed_flag;
    handled_n = handled;
    lost_n    = lost_pos;
    tee_n     = tee_pos;
    nontriv_n = nontriv_pos;
    ppos_n    = passed_pos;
    cur       = junction_of(pattern_next);
    prev      = now_junction;

    unique case (func)
      FUNC_SAMPLE: begin
        now_n = cur;
        if (prev != J_NONE && cur == J_NONE) begin
          lost_n = pos;
        end else if (prev != J_T && cur == J_T) begin
          tee_n = pos;
        end
        if (cur != J_NONE && cur != J_I) nontriv_n = pos;

        // latch the junction just left
        if (prev != cur && held != J_T && prev != J_NONE && prev != J_I) begin
          held_n    = prev;
          handled_n = 1'b0;
        end

        // classify once far enough past the last nontrivial junction
        if (!handled_n && reached(nontriv_n, pos, {16'd0, cfg.pass_delay_mm})) begin
          handled_n = 1'b1;
          if (cur == J_I || cur == J_NONE) begin
            pflag_n = 1'b1;
            if (cur == J_NONE) begin
              last_n = held_n;
            end else begin
              unique case (held_n)
                J_T:     last_n = J_X;
                J_G:     last_n = J_E;
                J_7:     last_n = J_3;
                J_NONE:  pflag_n = 1'b0;
                default: ;
              endcase
            end
            if (pflag_n) ppos_n = pos;
            if (cur == J_NONE) lost_n = pos;
            held_n = cur;
          end
        end

        if (last_n != J_DEAD && last_n != J_NONE && held_n == J_I && cur == J_NONE &&
            reached(lost_n, pos, {16'd0, cfg.dead_end_mm})) begin
          pflag_n = 1'b1;
          ppos_n  = pos;
          last_n  = J_DEAD;
        end

        if (last_n != J_NONE && prev == J_NONE && reached(lost_n, pos, LOST_REPORT_MM)) begin
          pflag_n = 1'b1;
          ppos_n  = pos;
          last_n  = J_NONE;
        end else if (last_n != J_F && prev == J_T && reached(tee_n, pos, F_REPORT_MM)) begin
          pflag_n = 1'b1;
          ppos_n  = pos;
          last_n  = J_F;
        end
      end
      FUNC_CLEAR: begin
        pflag_n   = 1'b0;
        held_n    = J_I;
        lost_n    = pos;
        nontriv_n = pos;
        handled_n = 1'b1;
      end
      default: ;
    endcase

    flag_out = pflag_n;
    if (func == FUNC_READ) pflag_n = 1'b0;
  end

  always_comb begin
    result.current    = now_n;
    result.filtered   = pattern_next;
    result.passed     = last_n;
    result.passed_pos = ppos_n;
    result.flag       = flag_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_junction <= J_NONE;
      held         <= J_NONE;
      last_passed  <= J_NONE;
      passed_flag  <= 1'b0;
      handled      <= 1'b1;
      lost_pos     <= '0;
      tee_pos      <= '0;
      nontriv_pos  <= '0;
      passed_pos   <= '0;
    end else if (step) begin
      now_junction <= now_n;
      held         <= held_n;
      last_passed  <= last_n;
      passed_flag  <= pflag_n;
      handled      <= handled_n;
      lost_pos     <= lost_n;
      tee_pos      <= tee_n;
      nontriv_pos  <= nontriv_n;
      passed_pos   <= ppos_n;
    end
  end

endmodule
